>>> rtl/bxpd_pkg.sv
// Shared widths, constants, the datapath step bundle and the 32-bit ones count
// for the binary xor/popcount dot-product block. No dependencies.

package bxpd_pkg;

  localparam int WORD_BITS        = 32;
  localparam int REM_BITS         = $clog2(WORD_BITS);
  localparam int FB_W             = 13;
  localparam int SCORE_W          = 14;
  localparam int MAX_FEATURE_BITS = 4096;
  localparam int CNT_W            = $clog2(MAX_FEATURE_BITS + 1);
  localparam int POP_W            = $clog2(WORD_BITS + 1);

  localparam logic [FB_W-1:0] FB_RESET = FB_W'(32);

  // one beat leaving the input register towards the accumulator
  typedef struct packed {
    logic                 go;
    logic                 last;
    logic [WORD_BITS-1:0] diff;
  } step_t;

  // SWAR ones count, five short levels
  function automatic logic [POP_W-1:0] ones_in_word(input logic [WORD_BITS-1:0] w);
    logic [WORD_BITS-1:0] v;
    v = w - ((w >> 1) & 32'h5555_5555);
    v = (v & 32'h3333_3333) + ((v >> 2) & 32'h3333_3333);
    v = (v + (v >> 4)) & 32'h0f0f_0f0f;
    v = v + (v >> 8);
    v = v + (v >> 16);
    return v[POP_W-1:0];
  endfunction

endpackage

>>> rtl/bxpd_dist.sv
// Running Hamming distance: ones count of each beat's difference word, saturating add.
// Depends on bxpd_pkg.

module bxpd_dist (
  input  logic                      clk,
  input  logic                      rst,
  input  bxpd_pkg::step_t           step,
  output logic [bxpd_pkg::CNT_W-1:0] total
);

  logic [bxpd_pkg::CNT_W-1:0] mismatch_count;
  logic [bxpd_pkg::CNT_W-1:0] mismatch_count_next;
  logic [bxpd_pkg::POP_W-1:0] pop;
  logic [bxpd_pkg::CNT_W:0]   sum;

  assign pop = bxpd_pkg::ones_in_word(step.diff);
  assign sum = {1'b0, mismatch_count} + (bxpd_pkg::CNT_W + 1)'(pop);

  always_comb begin
    if (sum > (bxpd_pkg::CNT_W + 1)'(bxpd_pkg::MAX_FEATURE_BITS)) begin
      total = bxpd_pkg::CNT_W'(bxpd_pkg::MAX_FEATURE_BITS);
    end else begin
      total = sum[bxpd_pkg::CNT_W-1:0];
    end
  end

  // cleared once the last beat of a vector has gone through
  assign mismatch_count_next = step.last ? '0 : total;

  always_ff @(posedge clk) begin
    if (rst) begin
      mismatch_count <= '0;
    end else if (step.go) begin
      mismatch_count <= mismatch_count_next;
    end
  end

endmodule

>>> rtl/binary_xor_popcount_dot.sv
// Top level of the binary xor/popcount dot product: input register, tail mask,
// score and result register. Depends on bxpd_pkg and bxpd_dist.
//
//   channel | signals                                   | direction
//   --------+-------------------------------------------+----------
//   input   | in_valid in_ready query_word key_word last_word | in
//   result  | out_valid out_ready score                 | out
//   config  | cfg_valid cfg_ready cfg_data (feature_bits) | in
//
// One beat is taken every cycle unless a stalled last beat holds the input
// register. The ones count and saturating add run from it into the distance
// register; a last beat's score lands in the result register.
// Only a last beat waits on a full result register; other beats keep flowing.
// Reset clears the distance, both valid flags and sets feature_bits to 32.
// The config port is always ready.

module binary_xor_popcount_dot (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [31:0]                   query_word,
  input  logic [31:0]                   key_word,
  input  logic                          last_word,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [13:0]            score,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bxpd_pkg::FB_W-1:0]     cfg_data
);

  logic [bxpd_pkg::FB_W-1:0]      feature_bits;
  logic                           s1_valid;
  logic [bxpd_pkg::WORD_BITS-1:0] s1_query;
  logic [bxpd_pkg::WORD_BITS-1:0] s1_key;
  logic                           s1_last;
  logic                           s1_go;
  logic                           out_free;
  logic [bxpd_pkg::REM_BITS-1:0]  rem;
  logic [bxpd_pkg::WORD_BITS-1:0] tail_mask;
  bxpd_pkg::step_t                step;
  logic [bxpd_pkg::CNT_W-1:0]     total;
  logic [bxpd_pkg::SCORE_W:0]     score_wide;
  logic signed [bxpd_pkg::SCORE_W-1:0] score_next;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      feature_bits <= bxpd_pkg::FB_RESET;
    end else if (cfg_valid && cfg_ready) begin
      feature_bits <= cfg_data;
    end
  end

  assign out_free = !out_valid || out_ready;
  assign s1_go    = s1_valid && (!s1_last || out_free);
  assign in_ready = !s1_valid || s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_query <= query_word;
      s1_key   <= key_word;
      s1_last  <= last_word;
    end
  end

  // whole word counts when feature_bits is a multiple of the word size
  assign rem = feature_bits[bxpd_pkg::REM_BITS-1:0];
  always_comb begin
    if (rem == '0) begin
      tail_mask = '1;
    end else begin
      tail_mask = (bxpd_pkg::WORD_BITS'(1) << rem) - bxpd_pkg::WORD_BITS'(1);
    end
  end

  assign step.go   = s1_go;
  assign step.last = s1_last;
  assign step.diff = (s1_query ^ s1_key) & (s1_last ? tail_mask : '1);

  bxpd_dist u_dist (
    .clk   (clk),
    .rst   (rst),
    .step  (step),
    .total (total)
  );

  // range is exactly [-8192, 8191], so truncation never wraps
  assign score_wide = (bxpd_pkg::SCORE_W + 1)'(feature_bits)
                    - ((bxpd_pkg::SCORE_W + 1)'(total) << 1);
  assign score_next = score_wide[bxpd_pkg::SCORE_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go && s1_last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_last) begin
      score <= score_next;
    end
  end

  // a held last beat must back up the input side
  a_last_backs_up: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_last && out_valid && !out_ready) |-> !in_ready)
    else $error("input taken while last beat stalled");

  // a result only appears from a last beat
  a_no_spurious_result: assert property (@(posedge clk) disable iff (rst)
    (!(s1_go && s1_last) && !(out_valid && !out_ready)) |=> !out_valid)
    else $error("result without last beat");

  // distance never exceeds its ceiling
  a_dist_bound: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> (total <= bxpd_pkg::CNT_W'(bxpd_pkg::MAX_FEATURE_BITS)))
    else $error("distance above ceiling");

endmodule

>>> sim/tb_binary_xor_popcount_dot.sv
// Self-checking testbench for binary_xor_popcount_dot: queue-fed driver, scoring monitor
// and a bit-level predictor of the xor/popcount distance and the dot-product score.
// Depends on bxpd_pkg and the block's RTL.

module tb_binary_xor_popcount_dot;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [bxpd_pkg::WORD_BITS-1:0] q;
    logic [bxpd_pkg::WORD_BITS-1:0] k;
    logic                           last;
  } pair_t;

  typedef enum {VEC_FULL, VEC_SHORT, VEC_LONG, VEC_NOISE} vec_kind_t;

  logic                                clk = 1'b0;
  logic                                rst = 1'b1;
  logic                                in_valid = 1'b0;
  logic                                in_ready;
  logic [bxpd_pkg::WORD_BITS-1:0]      query_word = '0;
  logic [bxpd_pkg::WORD_BITS-1:0]      key_word = '0;
  logic                                last_word = 1'b0;
  logic                                out_valid;
  logic                                out_ready = 1'b0;
  logic signed [bxpd_pkg::SCORE_W-1:0] score;
  logic                                cfg_valid = 1'b0;
  logic                                cfg_ready;
  logic [bxpd_pkg::FB_W-1:0]           cfg_data = '0;

  pair_t                               pending[$];
  logic signed [bxpd_pkg::SCORE_W-1:0] score_q[$];

  // predictor state
  logic [bxpd_pkg::FB_W-1:0]  feature_bits_cur = bxpd_pkg::FB_RESET;
  logic [bxpd_pkg::CNT_W-1:0] hamming_acc = '0;

  int send_gap_pct = 0;
  int stall_pct = 0;
  int errors = 0;
  int words_taken = 0;
  int scores_seen = 0;
  int settings_done = 0;

  binary_xor_popcount_dot dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .query_word (query_word),
    .key_word   (key_word),
    .last_word  (last_word),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .score      (score),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // distance update for one accepted beat; a last beat yields the expected score
  task automatic absorb_word(input logic [bxpd_pkg::WORD_BITS-1:0] q,
                             input logic [bxpd_pkg::WORD_BITS-1:0] k,
                             input logic last);
    logic [bxpd_pkg::WORD_BITS-1:0] diff;
    logic [4:0]                     tail;
    int                             run_dist;
    int                             dot;
    diff = q ^ k;
    tail = feature_bits_cur[4:0];
    if (last && tail != 5'd0)
      diff &= (32'h1 << tail) - 32'h1;
    run_dist = int'(hamming_acc) + $countones(diff);
    if (run_dist > bxpd_pkg::MAX_FEATURE_BITS)
      run_dist = bxpd_pkg::MAX_FEATURE_BITS;
    if (last) begin
      dot = int'(feature_bits_cur) - 2 * run_dist;
      if (dot > 8191)
        dot = 8191;
      if (dot < -8192)
        dot = -8192;
      score_q.push_back(bxpd_pkg::SCORE_W'(dot));
      hamming_acc = '0;
    end else begin
      hamming_acc = bxpd_pkg::CNT_W'(run_dist);
    end
  endtask

  // predictor follows every accepted beat and register write
  always @(posedge clk) begin
    if (rst) begin
      feature_bits_cur = bxpd_pkg::FB_RESET;
      hamming_acc = '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        feature_bits_cur = cfg_data;
        settings_done++;
      end
      if (in_valid && in_ready) begin
        absorb_word(query_word, key_word, last_word);
        words_taken++;
      end
    end
  end

  // driver
  always @(posedge clk) begin
    pair_t it;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (pending.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
        it = pending.pop_front();
        in_valid <= 1'b1;
        query_word <= it.q;
        key_word <= it.k;
        last_word <= it.last;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst)
      out_ready <= 1'b0;
    else
      out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // monitor
  always @(posedge clk) begin
    logic signed [bxpd_pkg::SCORE_W-1:0] want;
    if (!rst && out_valid && out_ready) begin
      if (score_q.size() == 0) begin
        $error("score: no result expected, got %0d", score);
        errors++;
      end else begin
        want = score_q.pop_front();
        if (score !== want) begin
          $error("score: expected %0d, got %0d", want, score);
          errors++;
        end
        scores_seen++;
      end
    end
  end

  task automatic push_pair(input logic [bxpd_pkg::WORD_BITS-1:0] q,
                           input logic [bxpd_pkg::WORD_BITS-1:0] k,
                           input logic last);
    pair_t it;
    it.q = q;
    it.k = k;
    it.last = last;
    pending.push_back(it);
  endtask

  // wait until every beat is in and every score out, then let the pipe settle
  task automatic drain();
    while (pending.size() != 0 || in_valid || score_q.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // called at a rising edge with the block idle
  task automatic write_feature_bits(input logic [bxpd_pkg::FB_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready)
      @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic queue_vector(input vec_kind_t kind, input logic [bxpd_pkg::FB_W-1:0] fb);
    int                             len;
    logic [bxpd_pkg::WORD_BITS-1:0] q;
    logic [bxpd_pkg::WORD_BITS-1:0] k;
    case (kind)
      VEC_FULL: begin
        len = (int'(fb) + bxpd_pkg::WORD_BITS - 1) / bxpd_pkg::WORD_BITS;
        if (len < 1)
          len = 1;
      end
      VEC_SHORT: len = $urandom_range(6, 1);
      VEC_LONG:  len = 129 + $urandom_range(40);
      default:   len = $urandom_range(3, 1);
    endcase
    for (int i = 0; i < len; i++) begin
      q = $urandom;
      if (kind == VEC_LONG) begin
        // mostly full mismatch so the distance hits its ceiling
        k = ($urandom_range(9) == 0) ? q ^ (32'h1 << $urandom_range(31)) : ~q;
      end else begin
        case ($urandom_range(3))
          0:       k = $urandom;
          1:       k = q;
          2:       k = ~q;
          default: k = q ^ (32'h1 << $urandom_range(31));
        endcase
      end
      // noise leaves a partial distance behind for the next vector
      push_pair(q, k, (kind != VEC_NOISE) && (i == len - 1));
    end
  endtask

  initial begin
    logic [bxpd_pkg::FB_W-1:0] fb_plan[12];
    logic [bxpd_pkg::FB_W-1:0] fb;
    int                        added;
    int                        pick;
    vec_kind_t                 kind;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed, reset width of 32: whole final word counts
    send_gap_pct = 23;
    stall_pct = 57;
    push_pair(32'h0000_0000, 32'h0000_0000, 1'b1);
    push_pair(32'hffff_ffff, 32'h0000_0000, 1'b1);
    push_pair(32'hffff_ffff, 32'hffff_ffff, 1'b1);
    push_pair(32'haaaa_aaaa, 32'h5555_5555, 1'b0);
    push_pair(32'h0000_0000, 32'hffff_ffff, 1'b1);
    push_pair(32'h8000_0000, 32'h0000_0000, 1'b0);
    push_pair(32'h0000_0001, 32'h0000_0000, 1'b1);
    drain();

    // directed, 5-bit tail: mask applies on the last beat only
    write_feature_bits(bxpd_pkg::FB_W'(5));
    push_pair(32'hffff_ffff, 32'h0000_0000, 1'b1);
    push_pair(32'h0000_0000, 32'hffff_ffe0, 1'b1);
    push_pair(32'hffff_ffff, 32'h0000_0000, 1'b0);
    push_pair(32'h0000_0010, 32'h0000_0000, 1'b1);
    push_pair(32'h1234_5678, 32'hedcb_a987, 1'b0);
    push_pair(32'hdead_beef, 32'hdead_beef, 1'b1);
    drain();

    fb_plan = '{bxpd_pkg::FB_W'(1), bxpd_pkg::FB_W'(4096), bxpd_pkg::FB_W'(0),
                bxpd_pkg::FB_W'(8191), bxpd_pkg::FB_W'(31), bxpd_pkg::FB_W'(33),
                bxpd_pkg::FB_W'(64), bxpd_pkg::FB_W'(100),
                bxpd_pkg::FB_W'($urandom_range(300, 1)),
                bxpd_pkg::FB_W'($urandom_range(8191)), bxpd_pkg::FB_W'(4095),
                bxpd_pkg::FB_W'(32)};

    for (int p = 0; p < 12; p++) begin
      if (p < 4) begin
        send_gap_pct = 23;
        stall_pct = 57;
      end else if (p < 8) begin
        send_gap_pct = 57;
        stall_pct = 23;
      end else begin
        send_gap_pct = 0;
        stall_pct = 0;
      end
      fb = fb_plan[p];
      write_feature_bits(fb);
      added = 0;
      while (added < 150) begin
        pick = $urandom_range(99);
        if (added == 0 && (p % 4) == 1)
          kind = VEC_LONG;
        else if (pick < 70)
          kind = VEC_FULL;
        else if (pick < 90)
          kind = VEC_SHORT;
        else if (pick < 94)
          kind = VEC_LONG;
        else
          kind = VEC_NOISE;
        pick = pending.size();
        queue_vector(kind, fb);
        added += pending.size() - pick;
      end
      drain();
    end

    repeat (8) @(posedge clk);
    if (score_q.size() != 0) begin
      $error("score: %0d results never arrived", score_q.size());
      errors++;
    end
    $display("Run covered %0d beats and %0d checked scores over %0d feature_bits writes.",
             words_taken, scores_seen, settings_done);
    $display("Mismatches seen: %0d", errors);
    if (errors == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  initial begin
    #20ms;
    $error("run did not finish in time");
    $display("*** FAILED ***");
    $finish;
  end

endmodule

>>> sim.f
rtl/bxpd_pkg.sv
rtl/bxpd_dist.sv
rtl/binary_xor_popcount_dot.sv
sim/tb_binary_xor_popcount_dot.sv
